FILE: hdl/sha256_pkg.sv
// SHA-256 hasher package: shared types, constants and round functions.
// No dependencies; used by every module of the hasher.
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_EMIT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic store_byte;   // append the accepted byte to the block
      logic start_block;  // load schedule window and round vars
      logic do_round;     // run one compression round
      logic update_chain; // add round vars into chain value
      logic pad_begin;    // write pad mark and clear the tail
      logic pad_second;   // clear the head for the second pad block
      logic pad_length;   // place the bit length in the last eight bytes
      logic restart;      // return to the initial hash values
      logic emit_shift;   // advance the digest output word
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic block_full;  // the byte being stored now fills the block
      logic pad_two;     // the pad mark landed at or past the length field
      logic last_round;  // round counter at 63
   } status_type;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos     = 56;
   localparam logic [7:0]  PadMark    = 8'h80;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

FILE: hdl/sha256_message_hasher_core.sv
// SHA-256 message hasher. Feed one transaction per message byte: tdata carries
// the byte, tuser[0] says the byte is valid and tlast closes the message. The
// byte that completes a 64-byte block holds off the input while the single
// round unit runs 64 rounds; no new byte is taken until that block is done.
// Closing the message pads and compresses one or two final blocks, then returns
// eight digest transactions, word 0 first, tlast on word 7, after which the
// hasher is back at the initial hash values ready for the next message.
module sha256_message_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [2:0]  word_index;
   logic [31:0] digest_word;

   sha256_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .byte_valid(req_tuser), .end_of_message(req_tlast),
      .rsp_tvalid, .rsp_tready, .rsp_last(rsp_tlast), .word_index,
      .status, .cmd
   );

   sha256_datapath u_dp (
      .clock, .reset, .msg_byte(req_tdata), .cmd, .status, .digest_word
   );

   // Pack word index above the digest word; pad to whole bytes.
   assign rsp_tdata = {5'b0, word_index, digest_word};
endmodule

FILE: hdl/sha256_ctrl.sv
// SHA-256 hasher controller: sequences byte intake, rounds, padding and output.
// Depends on sha256_pkg.
module sha256_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    byte_valid,
   input  logic                    end_of_message,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_last,
   output logic [2:0]              word_index,
   input  sha256_pkg::status_type  status,
   output sha256_pkg::cmd_type     cmd
);
   import sha256_pkg::*;

   state_type state_ff, state_in;
   logic      end_ff, end_in;     // message closes after the current block
   logic      pad_ff, pad_in;     // current block is a pad block
   logic      second_ff, second_in; // another pad block follows
   logic [2:0] idx_ff, idx_in;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in  = state_ff;
      end_in    = end_ff;
      pad_in    = pad_ff;
      second_in = second_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               end_in = end_of_message;
               pad_in = 1'b0;
               if (byte_valid && status.block_full) state_in = ST_LOAD;
               else if (end_of_message) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            pad_in    = 1'b1;
            second_in = status.pad_two;
            state_in  = ST_LOAD;
         end
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: if (status.last_round) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (!end_ff) state_in = ST_IDLE;
            else if (!pad_ff) state_in = ST_PAD;
            else if (second_ff) begin
               second_in = 1'b0;
               state_in  = ST_LOAD;
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  end_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_last   = (idx_ff == 3'd7);
      word_index = idx_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.store_byte = accept && byte_valid;
         ST_PAD: begin
            cmd.pad_begin  = 1'b1;
            cmd.pad_length = !status.pad_two;
         end
         ST_LOAD:   cmd.start_block = 1'b1;
         ST_ROUND:  cmd.do_round = 1'b1;
         ST_UPDATE: begin
            cmd.update_chain = 1'b1;
            cmd.pad_second   = end_ff && pad_ff && second_ff;
         end
         ST_EMIT: begin
            cmd.emit_shift = rsp_tready;
            cmd.restart    = rsp_tready && (idx_ff == 3'd7);
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         end_ff    <= 1'b0;
         pad_ff    <= 1'b0;
         second_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         end_ff    <= end_in;
         pad_ff    <= pad_in;
         second_ff <= second_in;
         idx_ff    <= idx_in;
      end
   end

   // Input is only taken while idle.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   // A round run always ends in an update.
   a_round_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && status.last_round) |=> (state_ff == ST_UPDATE))
      else $error("round run did not end");
   // Emit is only entered from an update of a final pad block.
   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_UPDATE && $past(pad_ff)))
      else $error("unexpected emit");
endmodule

FILE: hdl/sha256_datapath.sv
// SHA-256 hasher datapath: block buffer, bit count, schedule, rounds, chain.
// Depends on sha256_pkg.
module sha256_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              msg_byte,
   input  sha256_pkg::cmd_type     cmd,
   output sha256_pkg::status_type  status,
   output logic [31:0]             digest_word
);
   import sha256_pkg::*;

   logic [31:0] blk_ff [16];
   logic [63:0] count_ff;
   logic [31:0] win_ff [16];
   logic [31:0] var_ff [8];
   logic [31:0] chain_ff [8];
   logic [5:0]  round_ff;
   logic [5:0]  fill;
   logic [3:0]  word_sel;
   logic [1:0]  lane;
   logic [31:0] w, w2, w7, w15, w16, s0, s1, t1, t2, a, e;

   assign fill = count_ff[8:3];
   assign word_sel = fill[5:2];
   assign lane     = fill[1:0];
   assign status.block_full = (fill == 6'd63);
   assign status.pad_two    = (fill >= 6'(LenPos));
   assign status.last_round = (round_ff == 6'd63);
   assign digest_word = chain_ff[0];

   // Window is kept shifted so the current word sits at index 0.
   assign w16 = win_ff[0];
   assign w15 = win_ff[1];
   assign w7  = win_ff[9];
   assign w2  = win_ff[14];
   assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
   assign w   = win_ff[0];
   assign a   = var_ff[0];
   assign e   = var_ff[4];
   assign t1  = var_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & var_ff[5]) ^ (~e & var_ff[6])) + RoundConst[round_ff] + w;
   assign t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & var_ff[1]) ^ (a & var_ff[2]) ^ (var_ff[1] & var_ff[2]));

   // Block held as 16 big-endian words; byte lane 0 is the top byte of a word.
   always_ff @(posedge clock) begin
      if (cmd.store_byte)
         for (int j = 0; j < 4; j++)
            if (lane == 2'(j)) blk_ff[word_sel][31 - 8*j -: 8] <= msg_byte;
      if (cmd.pad_begin) begin
         for (int k = 0; k < 16; k++) begin
            if (4'(k) == word_sel) begin
               for (int j = 0; j < 4; j++) begin
                  if (2'(j) == lane) blk_ff[k][31 - 8*j -: 8] <= PadMark;
                  else if (2'(j) > lane) blk_ff[k][31 - 8*j -: 8] <= 8'h00;
               end
            end else if (4'(k) > word_sel) begin
               blk_ff[k] <= '0;
            end
         end
      end
      if (cmd.pad_second)
         for (int k = 0; k < LenPos / 4; k++) blk_ff[k] <= '0;
      if (cmd.pad_length || cmd.pad_second) begin
         blk_ff[LenPos / 4]     <= count_ff[63:32];
         blk_ff[LenPos / 4 + 1] <= count_ff[31:0];
      end
      if (cmd.start_block) begin
         for (int k = 0; k < 16; k++) win_ff[k] <= blk_ff[k];
         for (int k = 0; k < 8; k++) var_ff[k] <= chain_ff[k];
      end
      if (cmd.do_round) begin
         for (int k = 0; k < 15; k++) win_ff[k] <= win_ff[k+1];
         win_ff[15] <= s1 + w7 + s0 + w16;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         round_ff <= '0;
         for (int k = 0; k < 8; k++) chain_ff[k] <= InitHash[k];
      end else begin
         if (cmd.store_byte) count_ff <= count_ff + 64'd8;
         if (cmd.start_block) round_ff <= '0;
         else if (cmd.do_round) round_ff <= round_ff + 6'd1;
         if (cmd.update_chain)
            for (int k = 0; k < 8; k++) chain_ff[k] <= chain_ff[k] + var_ff[k];
         if (cmd.restart) begin
            count_ff <= '0;
            for (int k = 0; k < 8; k++) chain_ff[k] <= InitHash[k];
         end else if (cmd.emit_shift) begin
            for (int k = 0; k < 7; k++) chain_ff[k] <= chain_ff[k+1];
            chain_ff[7] <= chain_ff[0];
         end
      end
   end

   // Round counter only moves during rounds or at a block start.
   a_round_hold: assert property (@(posedge clock) disable iff (reset)
      (!cmd.do_round && !cmd.start_block) |=> $stable(round_ff))
      else $error("round counter moved");
   // Count advances by one byte per stored byte.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.store_byte && !cmd.restart) |=> (count_ff == $past(count_ff) + 64'd8))
      else $error("bit count slip");
   // Rounds and byte intake never overlap.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_round && cmd.store_byte)) else $error("round during intake");
endmodule

FILE: bench/sha256_message_hasher_core_tb.sv
`timescale 1ns / 100ps
// Testbench for sha256_message_hasher_core: byte stream in, digest words out.
// Depends on sha256_pkg for the initial hash values, round constants and pad constants.
module sha256_message_hasher_core_tb;
   import sha256_pkg::*;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;  // [7:0] msg_byte
   logic        req_tuser = 1'b0;   // [0] byte_valid
   logic        req_tlast = 1'b0;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] digest_word, [34:32] word_index
   logic        rsp_tlast;          // last_word

   // Shared controls: quiet turns off all idling, hold_off stalls the receiver.
   bit          quiet = 1'b0;
   logic        hold_off = 1'b0;
   bit          hold_go = 1'b0;
   int unsigned mismatch_count = 0;

   // Predicted hasher state.
   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   logic [63:0] message_bits;
   digest_word_type digest_queue [$];

   sha256_message_hasher_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Compress the predicted block into the predicted hash state.
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int k = 0; k < 16; k++)
         w[k] = {block_bytes[4*k], block_bytes[4*k+1], block_bytes[4*k+2], block_bytes[4*k+3]};
      for (int k = 16; k < 64; k++)
         w[k] = (ror32(w[k-2], 17) ^ ror32(w[k-2], 19) ^ (w[k-2] >> 10)) + w[k-7]
              + (ror32(w[k-15], 7) ^ ror32(w[k-15], 18) ^ (w[k-15] >> 3)) + w[k-16];
      for (int k = 0; k < 8; k++) v[k] = hash_state[k];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int k = 7; k > 0; k--) v[k] = v[k-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) hash_state[k] += v[k];
   endtask

   task automatic restart_hash();
      for (int k = 0; k < 8; k++) hash_state[k] = InitHash[k];
      message_bits = '0;
   endtask

   // Advance the predicted hasher by one accepted transaction.
   task automatic hash_item(logic [7:0] data, logic byte_valid, logic end_msg);
      int fill;
      logic [63:0] len;
      digest_word_type dw;
      if (byte_valid) begin
         fill = int'(message_bits[8:3]);
         block_bytes[fill] = data;
         message_bits += 64'd8;
         if (fill == 63) compress_block();
      end
      if (end_msg) begin
         len = message_bits;
         fill = int'(len[8:3]);
         block_bytes[fill] = PadMark;
         for (int k = fill + 1; k < 64; k++) block_bytes[k] = 8'h00;
         // pad mark at or past the length field needs a second block
         if (fill >= LenPos) begin
            compress_block();
            for (int k = 0; k < LenPos; k++) block_bytes[k] = 8'h00;
         end
         for (int k = 0; k < 8; k++) block_bytes[LenPos + k] = len[63 - 8*k -: 8];
         compress_block();
         for (int k = 0; k < 8; k++) begin
            dw.word = hash_state[k];
            dw.index = k[2:0];
            dw.last = (k == 7);
            digest_queue.push_back(dw);
         end
         restart_hash();
      end
   endtask

   // Offer one transaction, hold it until accepted, then update the prediction.
   task automatic send_item(logic [7:0] data, logic byte_valid, logic end_msg);
      if (!quiet && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= byte_valid;
      req_tlast  <= end_msg;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      hash_item(data, byte_valid, end_msg);
   endtask

   task automatic send_message(int len, bit mode_fill, logic [7:0] pattern);
      logic [7:0] b;
      bit join_end;
      join_end = (len > 0) && $urandom_range(1);
      for (int i = 0; i < len; i++) begin
         b = mode_fill ? pattern : 8'($urandom);
         // drop an ignored transaction in now and then
         if ($urandom_range(99) < 4) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(b, 1'b1, (i == len - 1) && join_end);
      end
      if (!join_end) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Drop the offer, then wait for every predicted digest word.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // Receiver: check each digest transaction, then pick the next ready.
   always @(posedge clock) begin
      digest_word_type exp_dw;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest transaction %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            exp_dw = digest_queue.pop_front();
            if (rsp_tdata[31:0] !== exp_dw.word || rsp_tdata[34:32] !== exp_dw.index ||
                rsp_tdata[39:35] !== 5'd0 || rsp_tlast !== exp_dw.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                           exp_dw.word, exp_dw.index, exp_dw.last,
                           rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
            end
         end
      end
      rsp_tready <= hold_off ? 1'b0 : (quiet ? 1'b1 : ($urandom_range(99) >= 11));
   end

   // Long receiver stall, counted here once a test asks for it.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (900) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Empty message, a byte carried with the close, extreme bytes, idle items.
   task automatic test_directed();
      send_item(8'h5a, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      wait_drained();
   endtask

   // Keep offering short messages while the receiver is stalled.
   task automatic test_backpressure();
      hold_go = 1'b1;
      for (int m = 0; m < 6; m++) send_message($urandom_range(3), 1'b0, 8'h00);
      wait_drained();
   endtask

   // Padding boundaries at full rate with no idling on either side.
   task automatic test_pad_boundaries();
      quiet = 1'b1;
      send_message(55, 1'b1, 8'hff);
      send_message(56, 1'b1, 8'h00);
      send_message(64, 1'b0, 8'h00);
      quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_random();
      int sent;
      int len;
      int pick;
      int edge_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      sent = 0;
      while (sent < 240) begin
         pick = $urandom_range(99);
         if (pick < 20) len = edge_lens[$urandom_range(7)];
         else len = $urandom_range(40);
         send_message(len, 1'b0, 8'h00);
         sent += len + 1;
      end
      wait_drained();
   endtask

   initial begin
      restart_hash();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_pad_boundaries();
      test_random();
      req_tvalid <= 1'b0;
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && digest_queue.size() == 0) begin
         $display("sha256_message_hasher_core_tb OK");
      end else begin
         $display("sha256_message_hasher_core_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("sha256_message_hasher_core_tb NOT OK");
      $finish;
   end

endmodule
